### hw/rtl/char_class_range_normalizer_top_macros.svh
`ifndef CHAR_CLASS_RANGE_NORMALIZER_TOP_MACROS_SVH
`define CHAR_CLASS_RANGE_NORMALIZER_TOP_MACROS_SVH

// same-cycle check, sampled on clk, off while arst_n is low
`define CCRN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// next-cycle check
`define CCRN_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) \
		else $error(msg);

`endif

### hw/rtl/ccrn_pkg.sv
package ccrn_pkg;

	typedef struct packed {
		logic ins;
		logic scan_step;
		logic close_last;
		logic tail;
		logic empty;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic close_need;
		logic tail_need;
		logic pend_v;
		logic slot_ok;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/ccrn_if.sv
interface ccrn_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] range_low;
	logic [15:0] range_high;
	logic        negate_class;
	logic        last_range;

	modport source (output valid, range_low, range_high, negate_class, last_range,
		input ready);
	modport sink (input valid, range_low, range_high, negate_class, last_range,
		output ready);
endinterface

interface ccrn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_low;
	logic [15:0] out_high;
	logic        out_last;
	logic        out_empty;
	logic        out_overflow;

	modport source (output valid, out_low, out_high, out_last, out_empty, out_overflow,
		input ready);
	modport sink (input valid, out_low, out_high, out_last, out_empty, out_overflow,
		output ready);
endinterface

### hw/rtl/ccrn_ctrl.sv
module ccrn_ctrl import ccrn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_TAIL  = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.ins  = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!sts.close_need || sts.slot_ok) begin
					if (sts.cnt_zero) begin
						cmd.close_last = 1'b1;
						state_d        = ST_TAIL;
					end else begin
						cmd.scan_step = 1'b1;
					end
				end
			end
			ST_TAIL: begin
				if (!sts.tail_need || sts.slot_ok) begin
					cmd.tail = 1'b1;
					state_d  = ST_EMPTY;
				end
			end
			ST_EMPTY: begin
				cmd.empty = !sts.pend_v;
				state_d   = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/ccrn_dp.sv
module ccrn_dp import ccrn_pkg::*; #(
	parameter int MAX_RANGES = 32,
	parameter int CODE_MAX   = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] range_low,
	input  logic [15:0] range_high,
	input  logic        negate_class,
	input  logic        last_range,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_low,
	output logic [15:0] out_high,
	output logic        out_last,
	output logic        out_empty,
	output logic        out_overflow
);

	localparam int              CNT_W    = $clog2(MAX_RANGES + 1);
	localparam logic [15:0]      CODE_TOP = 16'(CODE_MAX);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RANGES);

	logic [15:0]           row_s_q [MAX_RANGES];
	logic [15:0]           row_e_q [MAX_RANGES];
	logic [MAX_RANGES-1:0] take;

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             neg_q;
	logic             run_v_q;
	logic [15:0]      cur_s_q;
	logic [15:0]      cur_e_q;
	logic [16:0]      pos_q;

	logic        pend_v_q;
	logic [15:0] pend_lo_q;
	logic [15:0] pend_hi_q;
	logic        pend_empty_q;

	logic        out_v_q;
	logic [15:0] out_lo_q;
	logic [15:0] out_hi_q;
	logic        out_last_q;
	logic        out_empty_q;
	logic        out_ovf_q;

	logic [15:0] lo_c;
	logic [15:0] hi_c;
	logic [15:0] ins_s;
	logic [15:0] ins_e;
	logic        room;
	logic        cnt_zero;
	logic        merge;
	logic        close_need;
	logic        tail_need;
	logic        out_free;
	logic        emit_do;
	logic [15:0] emit_lo;
	logic [15:0] emit_hi;
	logic        emit_empty;

	// saturate, then order the pair
	assign lo_c  = (range_low > CODE_TOP) ? CODE_TOP : range_low;
	assign hi_c  = (range_high > CODE_TOP) ? CODE_TOP : range_high;
	assign ins_s = (lo_c > hi_c) ? hi_c : lo_c;
	assign ins_e = (lo_c > hi_c) ? lo_c : hi_c;
	assign room  = cnt_q < CNT_FULL;

	always_comb begin
		for (int i = 0; i < MAX_RANGES; i++) begin
			take[i] = (CNT_W'(i) >= cnt_q) || (row_s_q[i] > ins_s);
		end
	end

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		logic [15:0] left_s;
		logic [15:0] left_e;
		logic [15:0] right_s;
		logic [15:0] right_e;

		if (i == 0) begin : g_head
			assign left_s = ins_s;
			assign left_e = ins_e;
		end else begin : g_body
			assign left_s = take[i-1] ? row_s_q[i-1] : ins_s;
			assign left_e = take[i-1] ? row_e_q[i-1] : ins_e;
		end

		if (i < MAX_RANGES - 1) begin : g_next
			assign right_s = row_s_q[i+1];
			assign right_e = row_e_q[i+1];
		end else begin : g_end
			assign right_s = row_s_q[i];
			assign right_e = row_e_q[i];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins && room && take[i]) begin
				row_s_q[i] <= left_s;
				row_e_q[i] <= left_e;
			end else if (cmd.scan_step) begin
				row_s_q[i] <= right_s;
				row_e_q[i] <= right_e;
			end
		end
	end

	assign cnt_zero   = cnt_q == '0;
	assign merge      = {1'b0, row_s_q[0]} <= ({1'b0, cur_e_q} + 17'd1);
	assign close_need = run_v_q && (cnt_zero || !merge)
		&& (!neg_q || ({1'b0, cur_s_q} > pos_q));
	assign tail_need  = neg_q && (pos_q <= {1'b0, CODE_TOP});
	assign out_free   = !out_v_q || out_ready;
	assign emit_do    = ((cmd.scan_step || cmd.close_last) && close_need)
		|| (cmd.tail && tail_need) || cmd.empty;

	always_comb begin
		emit_empty = 1'b0;
		if (cmd.empty) begin
			emit_lo    = '0;
			emit_hi    = '0;
			emit_empty = 1'b1;
		end else if (cmd.tail) begin
			emit_lo = pos_q[15:0];
			emit_hi = CODE_TOP;
		end else if (neg_q) begin
			emit_lo = pos_q[15:0];
			emit_hi = cur_s_q - 16'd1;
		end else begin
			emit_lo = cur_s_q;
			emit_hi = cur_e_q;
		end
	end

	assign sts.cnt_zero   = cnt_zero;
	assign sts.close_need = close_need;
	assign sts.tail_need  = tail_need;
	assign sts.pend_v     = pend_v_q;
	assign sts.slot_ok    = !pend_v_q || out_free;
	assign sts.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			neg_q    <= 1'b0;
			run_v_q  <= 1'b0;
			pos_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.ins) begin
				if (room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (last_range) begin
					neg_q <= negate_class;
				end
			end
			if (cmd.scan_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (!run_v_q) begin
					run_v_q <= 1'b1;
				end else if (!merge) begin
					pos_q <= {1'b0, cur_e_q} + 17'd1;
				end
			end
			if (cmd.close_last) begin
				pos_q   <= {1'b0, cur_e_q} + 17'd1;
				run_v_q <= 1'b0;
			end
			if (emit_do) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
				ovf_q    <= 1'b0;
				pos_q    <= '0;
			end
			if (cmd.flush || (emit_do && pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (!run_v_q || !merge) begin
				cur_s_q <= row_s_q[0];
				cur_e_q <= row_e_q[0];
			end else if (row_e_q[0] > cur_e_q) begin
				cur_e_q <= row_e_q[0];
			end
		end
		if (emit_do) begin
			pend_lo_q    <= emit_lo;
			pend_hi_q    <= emit_hi;
			pend_empty_q <= emit_empty;
		end
		if (cmd.flush || (emit_do && pend_v_q)) begin
			out_lo_q    <= pend_lo_q;
			out_hi_q    <= pend_hi_q;
			out_empty_q <= pend_empty_q;
			out_last_q  <= cmd.flush;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid    = out_v_q;
	assign out_low      = out_lo_q;
	assign out_high     = out_hi_q;
	assign out_last     = out_last_q;
	assign out_empty    = out_empty_q;
	assign out_overflow = out_ovf_q;

endmodule

### hw/rtl/char_class_range_normalizer_top.sv
// channel  | dir | modport | word
// rng_in   | in  | sink    | range_low, range_high, negate_class, last_range
// rng_out  | out | source  | out_low, out_high, out_last, out_empty, out_overflow
//
// Loading takes one word per cycle, each word sorted into the range row on entry.
// After the last word the sweep reads the n stored ranges (up to MAX_RANGES), one per cycle
// unless rng_out stalls; tail, empty and flush steps follow before rng_in.ready rises again.
// Each result waits in a pending register until the next one is made, so the final one
// can carry out_last.
// A stalled rng_out holds the sweep whenever a new word needs the output register.
// Reset clears the controller, fill count and flags; the range row is not cleared.
module char_class_range_normalizer_top import ccrn_pkg::*; #(
	parameter int MAX_RANGES = 32,
	parameter int CODE_MAX   = 65535
) (
	input logic              clk,
	input logic              arst_n,
	ccrn_in_if.sink          rng_in,
	ccrn_out_if.source       rng_out
);

	cmd_t cmd;
	sts_t sts;

	ccrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rng_in.valid),
		.in_last  (rng_in.last_range),
		.in_ready (rng_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccrn_dp #(
		.MAX_RANGES (MAX_RANGES),
		.CODE_MAX   (CODE_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.range_low    (rng_in.range_low),
		.range_high   (rng_in.range_high),
		.negate_class (rng_in.negate_class),
		.last_range   (rng_in.last_range),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (rng_out.valid),
		.out_ready    (rng_out.ready),
		.out_low      (rng_out.out_low),
		.out_high     (rng_out.out_high),
		.out_last     (rng_out.out_last),
		.out_empty    (rng_out.out_empty),
		.out_overflow (rng_out.out_overflow)
	);

endmodule

### hw/rtl/ccrn_chk.sv
`include "char_class_range_normalizer_top_macros.svh"

module ccrn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_low,
	input logic [15:0] out_high,
	input logic        out_last,
	input logic        out_empty,
	input logic        out_overflow
);

	`CCRN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_low) && $stable(out_high) && $stable(out_last) && $stable(out_empty) && $stable(out_overflow), "output word changed while stalled")
	`CCRN_ASSERT(a_empty_form, out_valid && out_empty |-> out_last && out_low == 16'd0 && out_high == 16'd0, "empty word malformed")
	`CCRN_ASSERT(a_range_order, out_valid |-> out_low <= out_high, "output range reversed")
	`CCRN_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready, "input taken during sweep")

endmodule

bind char_class_range_normalizer_top ccrn_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rng_in.valid),
	.in_ready     (rng_in.ready),
	.in_last      (rng_in.last_range),
	.out_valid    (rng_out.valid),
	.out_ready    (rng_out.ready),
	.out_low      (rng_out.out_low),
	.out_high     (rng_out.out_high),
	.out_last     (rng_out.out_last),
	.out_empty    (rng_out.out_empty),
	.out_overflow (rng_out.out_overflow)
);
